// ===== rtl/core/sil_pkg.sv =====
// ----------------------------------------------------------------------------
// sil_pkg
// Shared types and constants for the sorted insertion list.
// ----------------------------------------------------------------------------
package sil_pkg;

    // Default number of stored values
    localparam int CAPACITY_DEF = 16;

    // Longest readout run, set by the 4-bit element position field
    localparam int MAX_READOUT = 16;

    // Field widths
    localparam int VALUE_W = 32;
    localparam int POS_W   = 4;
    localparam int COUNT_W = 5;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_value;    // capture the incoming value
        logic rd_en;         // memory read, data registered
        logic wr_en;         // memory write
        logic wr_sel_value;  // write the new value, else the read data
        logic out_load;      // load the output register
        logic out_last;      // last element of this readout run
        logic out_rejected;  // value of this step was dropped
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic ge;        // read data >= new value (signed)
        logic out_free;  // output register can take a new element
    } dp_status_t;

endpackage

// ===== rtl/core/sil_dpath.sv =====
// ----------------------------------------------------------------------------
// sil_dpath
// Value store, comparator and output register of the sorted insertion list.
// ----------------------------------------------------------------------------
module sil_dpath #(
    parameter int CAPACITY = sil_pkg::CAPACITY_DEF,
    parameter int ADDR_W   = $clog2(CAPACITY)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  sil_pkg::ctrl_cmd_t                  cmd,
    output sil_pkg::dp_status_t                 sts,
    input  logic [ADDR_W-1:0]                   rd_addr,
    input  logic [ADDR_W-1:0]                   wr_addr,
    input  logic [sil_pkg::POS_W-1:0]           out_position,
    input  logic [sil_pkg::COUNT_W-1:0]         out_count,
    input  logic signed [sil_pkg::VALUE_W-1:0]  s_new_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [sil_pkg::VALUE_W-1:0]  m_element_value,
    output logic [sil_pkg::POS_W-1:0]           m_element_position,
    output logic                                m_last_element,
    output logic                                m_value_rejected,
    output logic [sil_pkg::COUNT_W-1:0]         m_stored_count
);

    logic signed [sil_pkg::VALUE_W-1:0] mem [CAPACITY];
    logic signed [sil_pkg::VALUE_W-1:0] value_reg;
    logic signed [sil_pkg::VALUE_W-1:0] rd_data_reg;
    logic signed [sil_pkg::VALUE_W-1:0] wr_data;
    logic                               m_valid_reg;
    logic signed [sil_pkg::VALUE_W-1:0] out_value_reg;
    logic [sil_pkg::POS_W-1:0]          out_pos_reg;
    logic                               out_last_reg;
    logic                               out_rej_reg;
    logic [sil_pkg::COUNT_W-1:0]        out_count_reg;

    // Value being inserted
    always_ff @(posedge aclk) begin
        if (cmd.load_value) begin
            value_reg <= s_new_value;
        end
    end

    // Store: one write port, one registered read port
    assign wr_data = cmd.wr_sel_value ? value_reg : rd_data_reg;

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Status
    assign sts.ge       = (rd_data_reg >= value_reg);
    assign sts.out_free = !m_valid_reg || m_ready;

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_value_reg <= rd_data_reg;
            out_pos_reg   <= out_position;
            out_last_reg  <= cmd.out_last;
            out_rej_reg   <= cmd.out_rejected;
            out_count_reg <= out_count;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_element_value    = out_value_reg;
    assign m_element_position = out_pos_reg;
    assign m_last_element     = out_last_reg;
    assign m_value_rejected   = out_rej_reg;
    assign m_stored_count     = out_count_reg;

endmodule

// ===== rtl/core/sil_ctrl.sv =====
// ----------------------------------------------------------------------------
// sil_ctrl
// Controller of the sorted insertion list: insertion scan and readout run.
// ----------------------------------------------------------------------------
module sil_ctrl #(
    parameter int CAPACITY = sil_pkg::CAPACITY_DEF,
    parameter int ADDR_W   = $clog2(CAPACITY)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    output sil_pkg::ctrl_cmd_t          cmd,
    input  sil_pkg::dp_status_t         sts,
    output logic [ADDR_W-1:0]           rd_addr,
    output logic [ADDR_W-1:0]           wr_addr,
    output logic [sil_pkg::POS_W-1:0]   out_position,
    output logic [sil_pkg::COUNT_W-1:0] out_count
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int NW    = (CNT_W > sil_pkg::COUNT_W) ? CNT_W : sil_pkg::COUNT_W;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SEEK  = 4'b0010,
        ST_SHIFT = 4'b0100,
        ST_READ  = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [ADDR_W-1:0]  idx_reg, idx_next;
    logic [NW-1:0]      issue_reg, issue_next;
    logic [NW-1:0]      ld_pos_reg, ld_pos_next;
    logic               fetch_reg, fetch_next;
    logic               rej_reg, rej_next;
    logic [NW-1:0]      count_ext;
    logic [NW-1:0]      run_len;
    logic               is_last;
    logic               do_issue;

    // Readout length: stored count, at most one full position range
    assign count_ext = NW'(count_reg);
    assign run_len   = (count_ext >= NW'(sil_pkg::MAX_READOUT)) ?
                       NW'(sil_pkg::MAX_READOUT) : count_ext;
    assign is_last   = (ld_pos_reg == run_len - NW'(1));

    assign s_ready      = (state_reg == ST_IDLE);
    assign out_position = ld_pos_reg[sil_pkg::POS_W-1:0];
    assign out_count    = count_ext[sil_pkg::COUNT_W-1:0];

    // Next state and commands
    always_comb begin
        state_next  = state_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        issue_next  = issue_reg;
        ld_pos_next = ld_pos_reg;
        fetch_next  = fetch_reg;
        rej_next    = rej_reg;
        rd_addr     = '0;
        wr_addr     = idx_reg;
        do_issue    = 1'b0;
        cmd         = '0;
        cmd.out_last     = is_last;
        cmd.out_rejected = rej_reg;

        case (state_reg)
            ST_IDLE: begin
                issue_next  = '0;
                ld_pos_next = '0;
                fetch_next  = 1'b0;
                if (s_valid) begin
                    cmd.load_value = 1'b1;
                    if (count_reg == CNT_W'(CAPACITY)) begin
                        rej_next   = 1'b1;
                        state_next = ST_READ;
                    end else begin
                        rej_next   = 1'b0;
                        count_next = count_reg + CNT_W'(1);
                        idx_next   = count_reg[ADDR_W-1:0];
                        state_next = ST_SEEK;
                    end
                end
            end

            // Place the value at the bottom, or fetch the entry below the slot
            ST_SEEK: begin
                if (idx_reg == '0) begin
                    cmd.wr_en        = 1'b1;
                    cmd.wr_sel_value = 1'b1;
                    state_next       = ST_READ;
                end else begin
                    cmd.rd_en  = 1'b1;
                    rd_addr    = idx_reg - ADDR_W'(1);
                    state_next = ST_SHIFT;
                end
            end

            // Move entries >= value up one place, fetching the next one down
            ST_SHIFT: begin
                cmd.wr_en = 1'b1;
                if (sts.ge) begin
                    idx_next = idx_reg - ADDR_W'(1);
                    if (idx_reg == ADDR_W'(1)) begin
                        state_next = ST_SEEK;
                    end else begin
                        cmd.rd_en = 1'b1;
                        rd_addr   = idx_reg - ADDR_W'(2);
                    end
                end else begin
                    cmd.wr_sel_value = 1'b1;
                    state_next       = ST_READ;
                end
            end

            // Readout run: one fetch in flight ahead of the output register
            ST_READ: begin
                cmd.out_load = fetch_reg && sts.out_free;
                do_issue     = (!fetch_reg || cmd.out_load) && (issue_reg < run_len);
                rd_addr      = issue_reg[ADDR_W-1:0];
                cmd.rd_en    = do_issue;
                if (do_issue) begin
                    issue_next = issue_reg + NW'(1);
                    fetch_next = 1'b1;
                end else if (cmd.out_load) begin
                    fetch_next = 1'b0;
                end
                if (cmd.out_load) begin
                    ld_pos_next = ld_pos_reg + NW'(1);
                    if (is_last) begin
                        fetch_next = 1'b0;
                        state_next = ST_IDLE;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            idx_reg    <= '0;
            issue_reg  <= '0;
            ld_pos_reg <= '0;
            fetch_reg  <= 1'b0;
            rej_reg    <= 1'b0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            issue_reg  <= issue_next;
            ld_pos_reg <= ld_pos_next;
            fetch_reg  <= fetch_next;
            rej_reg    <= rej_next;
        end
    end

endmodule

// ===== rtl/core/sorted_insert_list.sv =====
// Sorted insertion list: each accepted value is inserted in ascending signed
// order into a store of CAPACITY entries (ahead of any equal entries); when
// the store is full the value is dropped and the step is flagged rejected.
// After every item the list is read out smallest first, one transfer per
// element, up to 16 elements, with last_element on the final transfer. An
// insertion moves every entry not below the new value up one place, one per
// cycle through the store's write port and the comparator, and the readout
// gives one element per cycle while m_ready stays high; output stalls hold
// it. The insertion scan and the readout share the one read port of the
// store. The last result of an item may still wait in the output register
// while the next item is accepted.
// ----------------------------------------------------------------------------
// sorted_insert_list
// Top level: controller, datapath and checks.
// ----------------------------------------------------------------------------
module sorted_insert_list #(
    parameter int CAPACITY = sil_pkg::CAPACITY_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [sil_pkg::VALUE_W-1:0]  s_new_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [sil_pkg::VALUE_W-1:0]  m_element_value,
    output logic [sil_pkg::POS_W-1:0]           m_element_position,
    output logic                                m_last_element,
    output logic                                m_value_rejected,
    output logic [sil_pkg::COUNT_W-1:0]         m_stored_count
);

    localparam int ADDR_W = $clog2(CAPACITY);

    sil_pkg::ctrl_cmd_t          cmd;
    sil_pkg::dp_status_t         sts;
    logic [ADDR_W-1:0]           rd_addr;
    logic [ADDR_W-1:0]           wr_addr;
    logic [sil_pkg::POS_W-1:0]   out_position;
    logic [sil_pkg::COUNT_W-1:0] out_count;

    sil_ctrl #(
        .CAPACITY (CAPACITY),
        .ADDR_W   (ADDR_W)
    ) u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .cmd          (cmd),
        .sts          (sts),
        .rd_addr      (rd_addr),
        .wr_addr      (wr_addr),
        .out_position (out_position),
        .out_count    (out_count)
    );

    sil_dpath #(
        .CAPACITY (CAPACITY),
        .ADDR_W   (ADDR_W)
    ) u_dpath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .sts                (sts),
        .rd_addr            (rd_addr),
        .wr_addr            (wr_addr),
        .out_position       (out_position),
        .out_count          (out_count),
        .s_new_value        (s_new_value),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_element_value    (m_element_value),
        .m_element_position (m_element_position),
        .m_last_element     (m_last_element),
        .m_value_rejected   (m_value_rejected),
        .m_stored_count     (m_stored_count)
    );

`ifndef SYNTHESIS
    // Read and write in one cycle never target the same entry
    a_no_rw_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.rd_en && cmd.wr_en) |-> (rd_addr != wr_addr))
        else $error("store read and write at the same entry");

    // The output register is only loaded when it is free
    a_out_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> sts.out_free)
        else $error("output register overwritten");

    // An accepted item keeps the block busy in the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while an item is in progress");
`endif

endmodule
